// ===== hdl/mscat_pkg.sv =====
// ----------------------------------------------------------------------------
// mscat_pkg
// Shared types and constants for the countdown alarm table.
// ----------------------------------------------------------------------------
`default_nettype none

package mscat_pkg;

  // Default table configuration
  localparam int NUM_SLOTS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 16;

  // Fixed port widths
  localparam int REQ_W     = 2;
  localparam int CNT_IN_W  = 16;
  localparam int HANDLER_W = 8;
  localparam int TAG_W     = 32;
  localparam int SLOT_W    = 5;
  localparam int KIND_W    = 3;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_SET    = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_SET_OK      = 3'd0,
    KIND_FULL        = 3'd1,
    KIND_CANCEL_DONE = 3'd2,
    KIND_EXPIRED     = 3'd3,
    KIND_TICK_DONE   = 3'd4,
    KIND_CLEARED     = 3'd5
  } kind_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SET_SCAN,
    ST_TICK_SCAN,
    ST_TICK_EMIT,
    ST_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic  load_req;   // capture request fields
    logic  do_cancel;  // free the requested slot
    logic  do_clear;   // free every slot
    logic  cnt_clr;    // slot counter to zero
    logic  cnt_inc;    // slot counter advance
    logic  alloc;      // load request into slot at counter
    logic  tick_upd;   // count down slot at counter
    logic  emit_fire;  // push expiry beat for slot at counter
    logic  emit_resp;  // push closing beat
    kind_t resp_kind;  // kind of the closing beat
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic busy_cur;  // slot at counter is occupied
    logic pend_cur;  // slot at counter expired this tick
    logic cnt_last;  // counter sits on the top slot
    logic out_free;  // output register can take a beat
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/mscat_dp.sv =====
// ----------------------------------------------------------------------------
// mscat_dp
// Slot store, slot counter, expiry flags and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mscat_dp #(
  parameter int NUM_SLOTS  = mscat_pkg::NUM_SLOTS_DEF,
  parameter int COUNT_BITS = mscat_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire mscat_pkg::ctl_cmd_t            cmd,
  output mscat_pkg::dp_stat_t                 stat,
  input  wire logic [mscat_pkg::CNT_IN_W-1:0]  count,
  input  wire logic [mscat_pkg::HANDLER_W-1:0] handler_id,
  input  wire logic [mscat_pkg::TAG_W-1:0]     user_tag,
  input  wire logic [mscat_pkg::SLOT_W-1:0]    slot,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [mscat_pkg::KIND_W-1:0]         kind,
  output logic [mscat_pkg::SLOT_W-1:0]         slot_index,
  output logic [mscat_pkg::HANDLER_W-1:0]      fired_handler,
  output logic [mscat_pkg::TAG_W-1:0]          fired_tag,
  output logic                                any_active,
  output logic                                last
);

  localparam int USED_SLOTS = (NUM_SLOTS < 32) ? NUM_SLOTS : 32;
  localparam int IDX_W      = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;

  // Slot store
  logic [USED_SLOTS-1:0]          busy;
  logic [USED_SLOTS-1:0]          pend;
  logic [COUNT_BITS-1:0]          remaining    [USED_SLOTS];
  logic [mscat_pkg::HANDLER_W-1:0] slot_handler [USED_SLOTS];
  logic [mscat_pkg::TAG_W-1:0]     slot_tag     [USED_SLOTS];

  // Captured request
  logic [COUNT_BITS-1:0]          req_count;
  logic [mscat_pkg::HANDLER_W-1:0] req_handler;
  logic [mscat_pkg::TAG_W-1:0]     req_tag;
  logic [mscat_pkg::SLOT_W-1:0]    req_slot;

  logic [IDX_W-1:0] cnt;
  logic             cur_expire;
  logic             any_busy;
  logic             cancel_hit;

  assign any_busy   = |busy;
  assign cur_expire = remaining[cnt] <= COUNT_BITS'(1);
  assign cancel_hit = 32'(slot) < USED_SLOTS;

  // Status back to controller
  always_comb begin
    stat.busy_cur = busy[cnt];
    stat.pend_cur = pend[cnt];
    stat.cnt_last = cnt == IDX_W'(USED_SLOTS - 1);
    stat.out_free = !out_valid || out_ready;
  end

  // Slot counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + IDX_W'(1);
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_count   <= COUNT_BITS'(count);
      req_handler <= handler_id;
      req_tag     <= user_tag;
      req_slot    <= slot;
    end
  end

  // Busy and expiry flags
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= '0;
      pend <= '0;
    end else begin
      if (cmd.do_clear) begin
        busy <= '0;
      end else if (cmd.do_cancel && cancel_hit) begin
        busy[slot[IDX_W-1:0]] <= 1'b0;
      end
      if (cmd.alloc) begin
        busy[cnt] <= 1'b1;
      end
      if (cmd.tick_upd && busy[cnt] && cur_expire) begin
        busy[cnt] <= 1'b0;
        pend[cnt] <= 1'b1;
      end
      if (cmd.emit_fire) begin
        pend[cnt] <= 1'b0;
      end
    end
  end

  // Slot payload store
  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      remaining[cnt]    <= req_count;
      slot_handler[cnt] <= req_handler;
      slot_tag[cnt]     <= req_tag;
    end else if (cmd.tick_upd && busy[cnt] && !cur_expire) begin
      remaining[cnt] <= remaining[cnt] - COUNT_BITS'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_fire || cmd.emit_resp) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_fire) begin
      kind          <= mscat_pkg::KIND_EXPIRED;
      slot_index    <= mscat_pkg::SLOT_W'(cnt);
      fired_handler <= slot_handler[cnt];
      fired_tag     <= slot_tag[cnt];
      any_active    <= any_busy;
      last          <= 1'b0;
    end else if (cmd.emit_resp) begin
      kind          <= cmd.resp_kind;
      fired_handler <= '0;
      fired_tag     <= '0;
      any_active    <= any_busy;
      last          <= 1'b1;
      if (cmd.resp_kind == mscat_pkg::KIND_SET_OK) begin
        slot_index <= mscat_pkg::SLOT_W'(cnt);
      end else if (cmd.resp_kind == mscat_pkg::KIND_CANCEL_DONE) begin
        slot_index <= req_slot;
      end else begin
        slot_index <= '0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mscat_ctrl.sv =====
// ----------------------------------------------------------------------------
// mscat_ctrl
// Request sequencer: free-slot search, tick countdown pass, expiry pass.
// ----------------------------------------------------------------------------
`default_nettype none

module mscat_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [mscat_pkg::REQ_W-1:0] req_type,
  input  wire mscat_pkg::dp_stat_t         stat,
  output mscat_pkg::ctl_cmd_t              cmd
);

  mscat_pkg::state_t state, state_next;
  mscat_pkg::kind_t  resp_kind, resp_kind_next;
  mscat_pkg::req_t   req;
  logic              acc;

  assign req = mscat_pkg::req_t'(req_type);
  assign acc = in_valid && (state == mscat_pkg::ST_IDLE);

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mscat_pkg::ST_IDLE;
      resp_kind <= mscat_pkg::KIND_SET_OK;
    end else begin
      state     <= state_next;
      resp_kind <= resp_kind_next;
    end
  end

  // Next state
  always_comb begin
    state_next     = state;
    resp_kind_next = resp_kind;
    unique case (state)
      mscat_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (req)
            mscat_pkg::REQ_SET:    state_next = mscat_pkg::ST_SET_SCAN;
            mscat_pkg::REQ_TICK:   state_next = mscat_pkg::ST_TICK_SCAN;
            mscat_pkg::REQ_CANCEL: begin
              state_next     = mscat_pkg::ST_RESP;
              resp_kind_next = mscat_pkg::KIND_CANCEL_DONE;
            end
            mscat_pkg::REQ_CLEAR: begin
              state_next     = mscat_pkg::ST_RESP;
              resp_kind_next = mscat_pkg::KIND_CLEARED;
            end
          endcase
        end
      end
      mscat_pkg::ST_SET_SCAN: begin
        if (!stat.busy_cur) begin
          state_next     = mscat_pkg::ST_RESP;
          resp_kind_next = mscat_pkg::KIND_SET_OK;
        end else if (stat.cnt_last) begin
          state_next     = mscat_pkg::ST_RESP;
          resp_kind_next = mscat_pkg::KIND_FULL;
        end
      end
      mscat_pkg::ST_TICK_SCAN: begin
        if (stat.cnt_last) begin
          state_next = mscat_pkg::ST_TICK_EMIT;
        end
      end
      mscat_pkg::ST_TICK_EMIT: begin
        if ((!stat.pend_cur || stat.out_free) && stat.cnt_last) begin
          state_next     = mscat_pkg::ST_RESP;
          resp_kind_next = mscat_pkg::KIND_TICK_DONE;
        end
      end
      mscat_pkg::ST_RESP: begin
        if (stat.out_free) begin
          state_next = mscat_pkg::ST_IDLE;
        end
      end
      default: state_next = mscat_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.resp_kind = resp_kind;
    unique case (state)
      mscat_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_req  = acc;
        cmd.cnt_clr   = acc;
        cmd.do_cancel = acc && (req == mscat_pkg::REQ_CANCEL);
        cmd.do_clear  = acc && (req == mscat_pkg::REQ_CLEAR);
      end
      mscat_pkg::ST_SET_SCAN: begin
        cmd.alloc   = !stat.busy_cur;
        cmd.cnt_inc = stat.busy_cur && !stat.cnt_last;
      end
      mscat_pkg::ST_TICK_SCAN: begin
        cmd.tick_upd = 1'b1;
        cmd.cnt_clr  = stat.cnt_last;
        cmd.cnt_inc  = !stat.cnt_last;
      end
      mscat_pkg::ST_TICK_EMIT: begin
        cmd.emit_fire = stat.pend_cur && stat.out_free;
        cmd.cnt_inc   = (!stat.pend_cur || stat.out_free) && !stat.cnt_last;
      end
      mscat_pkg::ST_RESP: begin
        cmd.emit_resp = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/multi_slot_countdown_alarm_table_core.sv =====
// ----------------------------------------------------------------------------
// multi_slot_countdown_alarm_table_core
// Table of countdown alarm slots with set, cancel, tick and clear-all.
// ----------------------------------------------------------------------------
// One request is handled at a time; a single slot counter walks the table one
// slot per clock while no expiry beat waits on the output, and the result
// register lets the next request be taken while the last beat still waits.
// With N = min(NUM_SLOTS, 32) slots: cancel and clear-all go straight to the
// response; a set scans from slot 0 up to the lowest free slot (all N slots
// when the table is full); a tick makes a countdown pass and an expiry pass
// over all slots, one beat per expired slot, then the done beat, and waits
// while the output is stalled. No clearing pass is needed after reset.
`default_nettype none

module multi_slot_countdown_alarm_table_core #(
  parameter int NUM_SLOTS  = mscat_pkg::NUM_SLOTS_DEF,
  parameter int COUNT_BITS = mscat_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [mscat_pkg::REQ_W-1:0]     req_type,
  input  wire logic [mscat_pkg::CNT_IN_W-1:0]  count,
  input  wire logic [mscat_pkg::HANDLER_W-1:0] handler_id,
  input  wire logic [mscat_pkg::TAG_W-1:0]     user_tag,
  input  wire logic [mscat_pkg::SLOT_W-1:0]    slot,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [mscat_pkg::KIND_W-1:0]         kind,
  output logic [mscat_pkg::SLOT_W-1:0]         slot_index,
  output logic [mscat_pkg::HANDLER_W-1:0]      fired_handler,
  output logic [mscat_pkg::TAG_W-1:0]          fired_tag,
  output logic                                 any_active,
  output logic                                 last
);

  mscat_pkg::ctl_cmd_t cmd;
  mscat_pkg::dp_stat_t stat;

  // Sequencer
  mscat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Slot store and result register
  mscat_dp #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .count         (count),
    .handler_id    (handler_id),
    .user_tag      (user_tag),
    .slot          (slot),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .slot_index    (slot_index),
    .fired_handler (fired_handler),
    .fired_tag     (fired_tag),
    .any_active    (any_active),
    .last          (last)
  );

endmodule

`default_nettype wire
